/* hdl/bba_pkg.sv */
// Shared types and constants of the block bitmap allocator.
// Used by every module of the block; depends on nothing.
package bba_pkg;

   localparam int MAX_BLOCKS  = 65536;
   localparam int WORD_BITS   = 64;
   localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int GROUPS      = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
   localparam int GROUP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int FULLW_W     = WORD_IDX_W + 1;
   localparam int COUNT_W     = 17;
   localparam int BLOCK_W     = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [2:0] KIND_FORMAT  = 3'd0;
   localparam logic [2:0] KIND_ALLOC   = 3'd1;
   localparam logic [2:0] KIND_RELEASE = 3'd2;
   localparam logic [2:0] KIND_QUERY   = 3'd3;
   localparam logic [2:0] KIND_WRITE   = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;

   localparam logic REG_TOTAL = 1'b0;
   localparam logic REG_META  = 1'b1;

   typedef struct packed {
      logic [2:0]         kind;
      logic [BLOCK_W-1:0] block_number;
      logic               bit_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [BLOCK_W-1:0] result_block;
      logic               bit_read;
      logic [COUNT_W-1:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] total_blocks;
      logic [COUNT_W-1:0] metadata_blocks;
   } cfg_type;

   typedef struct packed {
      logic                   map_re;
      logic [WORD_IDX_W-1:0]  map_raddr;
      logic                   map_we;
      logic [WORD_IDX_W-1:0]  map_waddr;
      logic [WORD_BITS-1:0]   map_wdata;
      logic                   sum_re;
      logic [GROUP_IDX_W-1:0] sum_raddr;
      logic                   sum_we;
      logic [GROUP_IDX_W-1:0] sum_waddr;
      logic [WORD_BITS-1:0]   sum_wdata;
   } store_cmd_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] map_rdata;
      logic [WORD_BITS-1:0] sum_rdata;
   } store_rd_type;

endpackage

/* hdl/bba_csr.sv */
// Configuration registers of the block bitmap allocator behind an APB-style port.
// Depends on bba_pkg.
module bba_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output bba_pkg::cfg_type               cfg
);
   import bba_pkg::*;

   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] meta_ff, meta_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      total_in = total_ff;
      meta_in  = meta_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_TOTAL: total_in = pwdata[COUNT_W-1:0];
            REG_META:  meta_in  = pwdata[COUNT_W-1:0];
            default:   total_in = total_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= COUNT_W'(MAX_BLOCKS);
         meta_ff  <= '0;
      end else begin
         total_ff <= total_in;
         meta_ff  <= meta_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TOTAL: prdata = CSR_DATA_W'(total_ff);
         REG_META:  prdata = CSR_DATA_W'(meta_ff);
         default:   prdata = '0;
      endcase
   end

   assign cfg.total_blocks    = total_ff;
   assign cfg.metadata_blocks = meta_ff;

endmodule

/* hdl/bba_store.sv */
// Occupancy map memory and word-full summary memory, both with registered reads.
// Depends on bba_pkg.
module bba_store (
   input  logic                   clock,
   input  bba_pkg::store_cmd_type cmd,
   output bba_pkg::store_rd_type  rd
);
   import bba_pkg::*;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] sum_mem [GROUPS];
   logic [WORD_BITS-1:0] map_rdata_ff;
   logic [WORD_BITS-1:0] sum_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.map_we) begin
         map_mem[cmd.map_waddr] <= cmd.map_wdata;
      end
      if (cmd.map_re) begin
         map_rdata_ff <= map_mem[cmd.map_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_we) begin
         sum_mem[cmd.sum_waddr] <= cmd.sum_wdata;
      end
      if (cmd.sum_re) begin
         sum_rdata_ff <= sum_mem[cmd.sum_raddr];
      end
   end

   assign rd.map_rdata = map_rdata_ff;
   assign rd.sum_rdata = sum_rdata_ff;

endmodule

/* hdl/bba_ctrl.sv */
// Sequencer of the block bitmap allocator: search, read-modify-write, format sweep.
// Depends on bba_pkg; drives the memories in bba_store.
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  bba_pkg::cfg_type       cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bba_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bba_pkg::rsp_type       rsp_data,
   output bba_pkg::store_cmd_type cmd,
   input  bba_pkg::store_rd_type  rd
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SUM   = 4'b0010,
      ST_MAP   = 4'b0100,
      ST_SWEEP = 4'b1000
   } state_type;

   typedef struct packed {
      logic                 found;
      logic [BIT_IDX_W-1:0] idx;
   } zero_pos_type;

   typedef struct packed {
      logic                   found;
      logic [GROUP_IDX_W-1:0] idx;
   } group_pos_type;

   // Lowest clear bit of a map or summary word.
   function automatic zero_pos_type first_zero(input logic [WORD_BITS-1:0] w);
      zero_pos_type r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r.found = 1'b1;
            r.idx   = BIT_IDX_W'(i);
         end
      end
      return r;
   endfunction

   // Lowest group that still holds a word with a free block.
   function automatic group_pos_type first_open_group(input logic [GROUPS-1:0] w);
      group_pos_type r;
      r = '0;
      for (int i = GROUPS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r.found = 1'b1;
            r.idx   = GROUP_IDX_W'(i);
         end
      end
      return r;
   endfunction

   state_type              state_ff, state_in;
   req_type                op_ff, op_in;
   logic [GROUP_IDX_W-1:0] grp_ff, grp_in;
   logic [WORD_IDX_W-1:0]  word_ff, word_in;
   logic                   fail_ff, fail_in;
   logic [COUNT_W-1:0]     free_ff, free_in;
   logic [GROUPS-1:0]      top_ff, top_in;
   logic [WORD_IDX_W-1:0]  sweep_ff, sweep_in;
   logic                   fmt_ff, fmt_in;
   logic [COUNT_W-1:0]     meta_ff, meta_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [COUNT_W-1:0]     eff_total;
   logic [COUNT_W-1:0]     clip_meta;
   logic                   out_free;
   group_pos_type          grp_pos;
   zero_pos_type           sum_pos;
   zero_pos_type           map_pos;
   logic [BIT_IDX_W-1:0]   bit_pos;
   logic [WORD_BITS-1:0]   bit_mask;
   logic [WORD_BITS-1:0]   new_word;
   logic [WORD_BITS-1:0]   new_sum;
   logic [COUNT_W-1:0]     alloc_block;
   logic                   in_range;
   logic [FULLW_W-1:0]     full_words;
   logic [FULLW_W-1:0]     sweep_word;
   logic [FULLW_W-1:0]     group_base;
   logic [FULLW_W-1:0]     group_left;
   logic [WORD_BITS-1:0]   fmt_word;
   logic [WORD_BITS-1:0]   fmt_sum;
   logic [GROUPS-1:0]      fmt_top;
   logic                   sweep_last;

   assign eff_total = (cfg.total_blocks > COUNT_W'(MAX_BLOCKS)) ?
                      COUNT_W'(MAX_BLOCKS) : cfg.total_blocks;
   assign clip_meta = (cfg.metadata_blocks > eff_total) ? eff_total : cfg.metadata_blocks;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign grp_pos   = first_open_group(top_ff);
   assign sum_pos   = first_zero(rd.sum_rdata);
   assign map_pos   = first_zero(rd.map_rdata);

   // Format image: whole words below the metadata boundary are full, the
   // boundary word is partly full and everything above it is clear.
   assign full_words = FULLW_W'(meta_ff >> BIT_IDX_W);
   assign sweep_word = FULLW_W'(sweep_ff);
   assign group_base = FULLW_W'(sweep_ff[GROUP_IDX_W-1:0]) << BIT_IDX_W;
   assign group_left = full_words - group_base;
   assign sweep_last = (sweep_ff == WORD_IDX_W'(MAP_WORDS - 1));

   always_comb begin
      if (sweep_word < full_words) begin
         fmt_word = '1;
      end else if (sweep_word == full_words) begin
         fmt_word = ~({WORD_BITS{1'b1}} << meta_ff[BIT_IDX_W-1:0]);
      end else begin
         fmt_word = '0;
      end
      if (full_words >= group_base + FULLW_W'(WORD_BITS)) begin
         fmt_sum = '1;
      end else if (full_words > group_base) begin
         fmt_sum = ~({WORD_BITS{1'b1}} << group_left[BIT_IDX_W-1:0]);
      end else begin
         fmt_sum = '0;
      end
      for (int g = 0; g < GROUPS; g++) begin
         fmt_top[g] = (full_words >= FULLW_W'((g + 1) * WORD_BITS));
      end
   end

   // Read-modify-write of the addressed map word.
   always_comb begin
      alloc_block = COUNT_W'({word_ff, map_pos.idx});
      in_range    = ({1'b0, op_ff.block_number} < eff_total);
      bit_pos     = (op_ff.kind == KIND_ALLOC) ? map_pos.idx :
                    op_ff.block_number[BIT_IDX_W-1:0];
      bit_mask    = WORD_BITS'(1) << bit_pos;
      new_word    = rd.map_rdata;
      case (op_ff.kind)
         KIND_ALLOC:   new_word = rd.map_rdata | bit_mask;
         KIND_RELEASE: new_word = rd.map_rdata & ~bit_mask;
         KIND_WRITE:   new_word = op_ff.bit_value ? (rd.map_rdata | bit_mask) :
                                                    (rd.map_rdata & ~bit_mask);
         default:      new_word = rd.map_rdata;
      endcase
      new_sum = rd.sum_rdata;
      new_sum[word_ff[BIT_IDX_W-1:0]] = &new_word;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      grp_in       = grp_ff;
      word_in      = word_ff;
      fail_in      = fail_ff;
      free_in      = free_ff;
      top_in       = top_ff;
      sweep_in     = sweep_ff;
      fmt_in       = fmt_ff;
      meta_in      = meta_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_data;
               unique case (req_data.kind)
                  KIND_FORMAT: begin
                     meta_in  = clip_meta;
                     fmt_in   = 1'b1;
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  KIND_ALLOC: begin
                     fail_in       = (free_ff == '0) || !grp_pos.found;
                     grp_in        = grp_pos.idx;
                     cmd.sum_re    = 1'b1;
                     cmd.sum_raddr = grp_pos.idx;
                     state_in      = ST_SUM;
                  end
                  default: begin
                     word_in       = WORD_IDX_W'(req_data.block_number >> BIT_IDX_W);
                     grp_in        = GROUP_IDX_W'(req_data.block_number >>
                                                  (BIT_IDX_W + BIT_IDX_W));
                     fail_in       = 1'b0;
                     cmd.map_re    = 1'b1;
                     cmd.map_raddr = WORD_IDX_W'(req_data.block_number >> BIT_IDX_W);
                     cmd.sum_re    = 1'b1;
                     cmd.sum_raddr = GROUP_IDX_W'(req_data.block_number >>
                                                  (BIT_IDX_W + BIT_IDX_W));
                     state_in      = ST_MAP;
                  end
               endcase
            end
         end

         ST_SUM: begin
            word_in       = WORD_IDX_W'({grp_ff, sum_pos.idx});
            fail_in       = fail_ff || !sum_pos.found;
            cmd.map_re    = 1'b1;
            cmd.map_raddr = WORD_IDX_W'({grp_ff, sum_pos.idx});
            state_in      = ST_MAP;
         end

         ST_MAP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.result_block = '0;
               rsp_in.bit_read     = 1'b0;
               case (op_ff.kind) inside
                  KIND_ALLOC: begin
                     if (fail_ff || !map_pos.found || (alloc_block >= eff_total)) begin
                        rsp_in.status = STATUS_NO_FREE;
                     end else begin
                        cmd.map_we          = 1'b1;
                        cmd.sum_we          = 1'b1;
                        top_in[grp_ff]      = &new_sum;
                        free_in             = free_ff - COUNT_W'(1);
                        rsp_in.result_block = alloc_block[BLOCK_W-1:0];
                     end
                  end
                  KIND_RELEASE, KIND_QUERY, KIND_WRITE: begin
                     rsp_in.result_block = op_ff.block_number;
                     if (!in_range) begin
                        rsp_in.status = STATUS_RANGE;
                     end else if (op_ff.kind == KIND_QUERY) begin
                        rsp_in.bit_read = rd.map_rdata[bit_pos];
                     end else begin
                        cmd.map_we     = 1'b1;
                        cmd.sum_we     = 1'b1;
                        top_in[grp_ff] = &new_sum;
                        if ((op_ff.kind == KIND_RELEASE) && (free_ff < eff_total)) begin
                           free_in = free_ff + COUNT_W'(1);
                        end
                     end
                  end
                  default: rsp_in.status = STATUS_OK;
               endcase
               rsp_in.free_count = free_in;
               state_in          = ST_IDLE;
            end
         end

         ST_SWEEP: begin
            cmd.map_we    = 1'b1;
            cmd.map_waddr = sweep_ff;
            cmd.map_wdata = fmt_word;
            cmd.sum_we    = (sweep_word < FULLW_W'(GROUPS));
            cmd.sum_waddr = sweep_ff[GROUP_IDX_W-1:0];
            cmd.sum_wdata = fmt_sum;
            if (!sweep_last) begin
               sweep_in = sweep_ff + WORD_IDX_W'(1);
            end else if (!fmt_ff) begin
               top_in   = fmt_top;
               state_in = ST_IDLE;
            end else if (out_free) begin
               top_in              = fmt_top;
               free_in             = eff_total - meta_ff;
               fmt_in              = 1'b0;
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.result_block = '0;
               rsp_in.bit_read     = 1'b0;
               rsp_in.free_count   = eff_total - meta_ff;
               state_in            = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (state_ff == ST_MAP) begin
         cmd.map_waddr = word_ff;
         cmd.map_wdata = new_word;
         cmd.sum_waddr = grp_ff;
         cmd.sum_wdata = new_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         fmt_ff       <= 1'b0;
         meta_ff      <= '0;
         free_ff      <= '0;
         top_ff       <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fmt_ff       <= fmt_in;
         meta_ff      <= meta_in;
         free_ff      <= free_in;
         top_ff       <= top_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      grp_ff  <= grp_in;
      word_ff <= word_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/block_bitmap_allocator.sv */
// Top level of the block bitmap allocator: configuration port, sequencer, memories.
// Depends on bba_pkg, bba_csr, bba_store and bba_ctrl.
//
// Usage: requests arrive on the req_ channel (valid/ready), one transaction per
// operation: format, allocate, release, query or write of one map bit. Every
// request produces exactly one rsp_ transaction carrying status, the block,
// the bit read and the free count after the operation.
// Steps: release, query, write and unknown kinds read the map and summary
// words on acceptance and reach the response register from ST_MAP once the
// output register is free; allocate first picks a group from a register of
// group-full bits and does one registered read of the word-full summary
// memory, then one registered read of the map memory. The sequencer takes no
// new request until the response is loaded, when it returns to ST_IDLE.
// Format rewrites all 1024 map words, one per cycle through the map memory
// write port, and answers when the last word is written and the output is free.
// Reset runs the same sweep with zero metadata, clearing map and summary;
// req_ready stays low during it, while csr_ writes are taken at any time.
// A stalled receiver holds the result in the output register; the block still
// accepts one more request and finishes it as soon as that register is taken.
module block_bitmap_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bba_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bba_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bba_pkg::*;

   cfg_type       cfg;
   store_cmd_type store_cmd;
   store_rd_type  store_rd;

   // Register file: total_blocks at byte address 0, metadata_blocks at 4.
   bba_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // The sequencer owns the free count and the group-full bits; the map and
   // its per-word summary live in the memories below.
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (store_cmd),
      .rd        (store_rd)
   );

   bba_store u_store (
      .clock (clock),
      .cmd   (store_cmd),
      .rd    (store_rd)
   );

endmodule

/* bench/block_bitmap_allocator_tb.sv */
// Self-checking testbench for the block bitmap allocator: a directed table, then
// random phases under changing register settings, checked against a predictor.
// Depends on bba_pkg and block_bitmap_allocator.
`timescale 1ns / 1ps

module block_bitmap_allocator_tb;
   import bba_pkg::*;

   // Kind codes the block does not define; they must leave the state untouched.
   localparam logic [2:0] KIND_UNDEFINED = 3'd5;
   localparam logic [2:0] KIND_LAST_CODE = 3'd7;

   // Number of random request transactions after the directed table.
   localparam int unsigned RANDOM_ITEMS = 1150;
   // Cycles the receiver refuses results when a long hold-off is requested.
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   // Cycles allowed after the last result before the verdict.
   localparam int unsigned TAIL_CYCLES = 20;
   // The slowest legal run is dominated by format passes.
   localparam int unsigned CYCLE_LIMIT = 600000;

   // One row of the directed table: either a register setting or a request.
   // Rows with a typed response carry it in typed_rsp; the others are
   // checked against the predictor.
   typedef struct {
      bit                 is_cfg;
      logic [COUNT_W-1:0] cfg_total;
      logic [COUNT_W-1:0] cfg_meta;
      req_type            op;
      bit                 typed;
      rsp_type            typed_rsp;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state: the occupancy map, the free count and the two registers.
   logic [WORD_BITS-1:0] model_map [MAP_WORDS];
   logic [COUNT_W-1:0]   model_free;
   logic [COUNT_W-1:0]   model_total;
   logic [COUNT_W-1:0]   model_meta;

   rsp_type        awaited_responses [$];
   script_row_type directed_script [$];
   int unsigned    error_count = 0;
   int unsigned    cycle_count = 0;
   // The stimulus raises this count to ask the receiver for a long hold-off;
   // the receiver keeps its own count of the hold-offs it has served.
   int unsigned hold_off_requests = 0;

   block_bitmap_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // A total above the map size acts as the map size.
   function automatic int unsigned active_total();
      return (model_total > MAX_BLOCKS) ? MAX_BLOCKS : int'(model_total);
   endfunction

   // Applies one request to the predictor state and returns the response the
   // block must give for it.
   function automatic rsp_type allocator_response(req_type op);
      int unsigned lim;
      int unsigned meta;
      int unsigned blk;
      int unsigned found_block;
      bit          found;
      rsp_type     rsp;
      lim = active_total();
      blk = op.block_number;
      found = 1'b0;
      found_block = 0;
      rsp = '0;
      case (op.kind)
         KIND_FORMAT: begin
            // Metadata larger than the total only fills the total.
            meta = (model_meta > lim) ? lim : int'(model_meta);
            for (int w = 0; w < MAP_WORDS; w++) begin
               if ((w + 1) * WORD_BITS <= meta)
                  model_map[w] = '1;
               else if (w * WORD_BITS < meta)
                  model_map[w] = (64'd1 << (meta - w * WORD_BITS)) - 64'd1;
               else
                  model_map[w] = '0;
            end
            model_free = COUNT_W'(lim - meta);
         end
         KIND_ALLOC: begin
            // First fit below the total. Full words are skipped, as the
            // block's summary bits do; a write may have filled the map
            // behind a nonzero count, and then nothing is found.
            if (model_free != 0) begin
               for (int w = 0; w < MAP_WORDS && w * WORD_BITS < lim && !found; w++) begin
                  if (model_map[w] != '1) begin
                     for (int b = 0; b < WORD_BITS && !found; b++) begin
                        if (w * WORD_BITS + b < lim && !model_map[w][b]) begin
                           found = 1'b1;
                           found_block = w * WORD_BITS + b;
                        end
                     end
                  end
               end
            end
            if (found) begin
               model_map[found_block / WORD_BITS][found_block % WORD_BITS] = 1'b1;
               model_free = model_free - 1'b1;
               rsp.result_block = BLOCK_W'(found_block);
            end else begin
               rsp.status = STATUS_NO_FREE;
            end
         end
         KIND_RELEASE: begin
            rsp.result_block = op.block_number;
            if (blk >= lim) begin
               rsp.status = STATUS_RANGE;
            end else begin
               // Releasing a free block still counts, up to the total.
               model_map[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
               if (model_free < lim)
                  model_free = model_free + 1'b1;
            end
         end
         KIND_QUERY: begin
            rsp.result_block = op.block_number;
            if (blk >= lim)
               rsp.status = STATUS_RANGE;
            else
               rsp.bit_read = model_map[blk / WORD_BITS][blk % WORD_BITS];
         end
         KIND_WRITE: begin
            rsp.result_block = op.block_number;
            if (blk >= lim)
               rsp.status = STATUS_RANGE;
            else
               model_map[blk / WORD_BITS][blk % WORD_BITS] = op.bit_value;
         end
         default: begin
         end
      endcase
      rsp.free_count = model_free;
      return rsp;
   endfunction

   // Directed table builders: a register setting, a request checked by the
   // predictor, and a request whose response is typed in.
   function automatic void cfg_row(int unsigned total, int unsigned meta);
      script_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.cfg_total = COUNT_W'(total);
      row.cfg_meta = COUNT_W'(meta);
      directed_script.push_back(row);
   endfunction

   function automatic void op_row(logic [2:0] kind, int unsigned blk, bit bv);
      script_row_type row;
      row = '{default: '0};
      row.op.kind = kind;
      row.op.block_number = BLOCK_W'(blk);
      row.op.bit_value = bv;
      directed_script.push_back(row);
   endfunction

   function automatic void fixed_row(logic [2:0] kind, int unsigned blk, bit bv,
                                     logic [1:0] status, int unsigned res, bit bitr,
                                     int unsigned free);
      script_row_type row;
      row = '{default: '0};
      row.op.kind = kind;
      row.op.block_number = BLOCK_W'(blk);
      row.op.bit_value = bv;
      row.typed = 1'b1;
      row.typed_rsp.status = status;
      row.typed_rsp.result_block = BLOCK_W'(res);
      row.typed_rsp.bit_read = bitr;
      row.typed_rsp.free_count = COUNT_W'(free);
      directed_script.push_back(row);
   endfunction

   // Offers one request transaction and waits until it is accepted. Ready is
   // sampled at the falling edge, where it already holds its value for the
   // next rising edge, so acceptance never depends on event order.
   task automatic send_op(req_type op, bit typed, rsp_type typed_rsp);
      bit      ready_seen;
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data <= op;
      do begin
         @(negedge clock);
         ready_seen = (req_ready === 1'b1);
         @(posedge clock);
      end while (!ready_seen);
      // The predictor always runs so that its state follows the block,
      // even on rows that carry a typed response.
      predicted = allocator_response(op);
      awaited_responses.push_back(typed ? typed_rsp : predicted);
   endtask

   // The sender pauses for the given number of cycles.
   task automatic sender_gap(int unsigned cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // The sender stops until every expected response has been taken.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (awaited_responses.size() != 0);
   endtask

   // One register write followed by a read back of the same register. The
   // read data is sampled in the access phase, at the falling edge.
   task automatic write_reg(logic idx, logic [COUNT_W-1:0] value);
      bit ready_seen;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ready_seen = (csr_pready === 1'b1);
         @(posedge clock);
      end while (!ready_seen);
      if (idx == REG_TOTAL)
         model_total = value;
      else
         model_meta = value;
      // Straight into the setup phase of the read back.
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ready_seen = (csr_pready === 1'b1);
         if (ready_seen && csr_prdata !== CSR_DATA_W'(value)) begin
            $error("csr_prdata at %0d: expected %0d, actual %0d",
                   {idx, 2'b00}, value, csr_prdata);
            error_count++;
         end
         @(posedge clock);
      end while (!ready_seen);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Response checker. A transaction is taken at the rising edge that
   // follows a falling edge with valid and ready both high, and it is
   // compared with the oldest expectation.
   always @(negedge clock) begin
      rsp_type awaited;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (awaited_responses.size() == 0) begin
            $error("response transaction with no request waiting for it");
            error_count++;
         end else begin
            awaited = awaited_responses.pop_front();
            if (rsp_data.status !== awaited.status) begin
               $error("status: expected %0d, actual %0d", awaited.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.result_block !== awaited.result_block) begin
               $error("result_block: expected %0d, actual %0d",
                      awaited.result_block, rsp_data.result_block);
               error_count++;
            end
            if (rsp_data.bit_read !== awaited.bit_read) begin
               $error("bit_read: expected %0d, actual %0d",
                      awaited.bit_read, rsp_data.bit_read);
               error_count++;
            end
            if (rsp_data.free_count !== awaited.free_count) begin
               $error("free_count: expected %0d, actual %0d",
                      awaited.free_count, rsp_data.free_count);
               error_count++;
            end
         end
      end
   end

   // Receiver. It runs in segments of random length, each with its own
   // pattern: always ready, coin flips, mostly stalled, or a fixed on/off
   // rhythm. A requested hold-off keeps ready low long enough for the block
   // to fill up and push back on the request channel.
   initial begin
      int unsigned mode;
      int unsigned segment_left;
      int unsigned hold_offs_served;
      mode = 0;
      segment_left = 0;
      hold_offs_served = 0;
      forever begin
         if (hold_off_requests > hold_offs_served) begin
            hold_offs_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (segment_left == 0) begin
               mode = $urandom_range(0, 3);
               segment_left = $urandom_range(10, 80);
            end
            segment_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ((segment_left % 6) < 3);
            endcase
            @(posedge clock);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      script_row_type     row;
      req_type            op;
      int unsigned        random_sent;
      int unsigned        phase;
      int unsigned        phase_ops;
      int unsigned        burst_left;
      int unsigned        lim;
      int unsigned        pick;
      logic [COUNT_W-1:0] new_total;
      logic [COUNT_W-1:0] new_meta;

      // Predictor state after reset: map clear, no free blocks until the
      // first format, registers at their reset values.
      foreach (model_map[w])
         model_map[w] = '0;
      model_free = '0;
      model_total = COUNT_W'(MAX_BLOCKS);
      model_meta = '0;

      // Right after reset: no free blocks yet, every block in range.
      fixed_row(KIND_QUERY,     0,       0, STATUS_OK,      0,       0, 0);
      fixed_row(KIND_ALLOC,     0,       0, STATUS_NO_FREE, 0,       0, 0);
      // Releasing a block that is already free still raises the count.
      fixed_row(KIND_RELEASE,   16'hFFFF, 0, STATUS_OK,     16'hFFFF, 0, 1);
      fixed_row(KIND_UNDEFINED, 16'h1234, 1, STATUS_OK,     0,       0, 1);

      // A small map with leading metadata blocks.
      cfg_row(100, 10);
      op_row(KIND_FORMAT, 0, 0);
      op_row(KIND_ALLOC, 0, 0);
      fixed_row(KIND_QUERY,   100,      0, STATUS_RANGE, 100,      0, 89);
      fixed_row(KIND_RELEASE, 16'hFFFF, 0, STATUS_RANGE, 16'hFFFF, 0, 89);
      op_row(KIND_WRITE, 11, 1);
      op_row(KIND_ALLOC, 0, 0);
      op_row(KIND_RELEASE, 10, 0);

      // Three blocks: a write fills the map behind a nonzero count, and a
      // repeated release saturates the count at the total.
      cfg_row(3, 1);
      op_row(KIND_FORMAT, 0, 0);
      op_row(KIND_ALLOC, 0, 0);
      op_row(KIND_WRITE, 2, 1);
      fixed_row(KIND_ALLOC, 0, 0, STATUS_NO_FREE, 0, 0, 1);
      op_row(KIND_RELEASE, 2, 0);
      op_row(KIND_RELEASE, 0, 0);
      op_row(KIND_RELEASE, 0, 0);

      // Both registers at their largest: total clamps, metadata fills it.
      cfg_row(17'h1FFFF, 17'h1FFFF);
      fixed_row(KIND_FORMAT,  0,        0, STATUS_OK, 0,        0, 0);
      fixed_row(KIND_RELEASE, 16'hFFFF, 0, STATUS_OK, 16'hFFFF, 0, 1);
      fixed_row(KIND_ALLOC,   0,        0, STATUS_OK, 16'hFFFF, 0, 0);

      // A total of zero puts every block out of range.
      cfg_row(0, 0);
      fixed_row(KIND_ALLOC, 0, 0, STATUS_NO_FREE, 0, 0, 0);
      fixed_row(KIND_QUERY, 0, 0, STATUS_RANGE,   0, 0, 0);

      // A single block.
      cfg_row(1, 0);
      fixed_row(KIND_FORMAT, 0, 0, STATUS_OK, 0, 0, 1);
      fixed_row(KIND_ALLOC,  0, 0, STATUS_OK, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The block keeps req_ready low through its clearing pass, so the
      // first transaction simply waits for it.
      foreach (directed_script[i]) begin
         row = directed_script[i];
         if (row.is_cfg) begin
            wait_for_drain();
            write_reg(REG_TOTAL, row.cfg_total);
            write_reg(REG_META, row.cfg_meta);
         end else begin
            send_op(row.op, row.typed, row.typed_rsp);
         end
      end

      // Random phases. Each one drains, picks new register values, formats
      // the map and then runs a mix of operations that favors allocation, so
      // that small maps fill up and run dry.
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_for_drain();
         pick = $urandom_range(0, 9);
         if (pick < 5)
            new_total = COUNT_W'($urandom_range(1, 150));
         else if (pick < 7)
            new_total = COUNT_W'($urandom_range(151, 4000));
         else if (pick == 7)
            new_total = COUNT_W'(MAX_BLOCKS);
         else if (pick == 8)
            new_total = COUNT_W'($urandom_range(MAX_BLOCKS + 1, 17'h1FFFF));
         else
            new_total = '0;
         pick = $urandom_range(0, 19);
         if (pick < 14)
            new_meta = COUNT_W'($urandom_range(0, new_total / 2));
         else if (pick < 17)
            new_meta = '0;
         else
            new_meta = COUNT_W'($urandom());
         write_reg(REG_TOTAL, new_total);
         write_reg(REG_META, new_meta);
         lim = active_total();

         op.kind = KIND_FORMAT;
         op.block_number = BLOCK_W'($urandom());
         op.bit_value = 1'($urandom_range(0, 1));
         send_op(op, 1'b0, '0);
         random_sent++;

         // Twice in the run the receiver holds off while the sender keeps
         // offering without gaps, so the request channel must stall.
         if (phase == 1 || phase == 6) begin
            hold_off_requests++;
            burst_left = 60;
         end else begin
            burst_left = 0;
         end

         phase_ops = $urandom_range(60, 120);
         for (int n = 0; n < phase_ops && random_sent < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
               if ($urandom_range(0, 3) != 0)
                  sender_gap($urandom_range(1, 10));
               burst_left = $urandom_range(1, 24);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
               op.kind = KIND_ALLOC;
            else if (pick < 60)
               op.kind = KIND_RELEASE;
            else if (pick < 78)
               op.kind = KIND_QUERY;
            else if (pick < 93)
               op.kind = KIND_WRITE;
            else if (pick < 95)
               op.kind = KIND_FORMAT;
            else
               op.kind = 3'($urandom_range(KIND_UNDEFINED, KIND_LAST_CODE));
            // Mostly blocks inside the map; the rest spread over all 16 bits.
            if (lim > 0 && $urandom_range(0, 9) < 8)
               op.block_number = BLOCK_W'($urandom_range(0, lim - 1));
            else
               op.block_number = BLOCK_W'($urandom());
            op.bit_value = 1'($urandom_range(0, 1));
            send_op(op, 1'b0, '0);
            burst_left--;
            random_sent++;
         end
         phase++;
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_responses.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
hdl/bba_pkg.sv
hdl/bba_csr.sv
hdl/bba_store.sv
hdl/bba_ctrl.sv
hdl/block_bitmap_allocator.sv
bench/block_bitmap_allocator_tb.sv
